// ===== sv/signed_int_to_decimal_ascii_unit_defines.svh =====
// Assertion helpers shared by the RTL
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Clocked implication, disabled while reset is asserted
`define SITDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked implication whose consequent is checked in the next cycle
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sitda_pkg.sv =====
package sitda_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int NUM_CELLS = 10;
    localparam int CNT_W     = 5;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 6'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 6'd45;
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;
    localparam logic [CNT_W-1:0]   CONV_LAST    = 5'd31;
    localparam logic [CNT_W-1:0]   OUT_COUNT    = 5'd10;

    // control word driven to every digit cell
    typedef struct packed {
        logic clear;    // zero the digit
        logic dabble;   // add-3 correction then shift in one binary bit
        logic advance;  // take the digit of the lower neighbor
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_OUT
    } t_state;

endpackage

// ===== sv/signed_int_to_decimal_ascii_unit.sv =====
// Flow: after accept, a double-dabble pass over all 32 magnitude bits, then
// one digit position per cycle; a minus sign is strobed before the first digit
// when negative, leading zeros give no strobe.
// A new number is taken only when idle (busy low), not during a conversion.
// Reset: synchronous, active low, returns to idle and drops the strobe.
// The receiver cannot stall; each character is valid for one cycle only.
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module signed_int_to_decimal_ascii_unit
    import sitda_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    output logic [CHAR_W-1:0]         o_character,
    output logic                      o_last
);

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_mag,   n_mag;
    logic               r_neg,   n_neg;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_seen,  n_seen;
    logic               r_valid, n_valid;
    logic [CHAR_W-1:0]  r_char,  n_char;
    logic               r_last,  n_last;

    t_cell_ctrl         w_ctrl;
    logic               w_accept;
    logic [VALUE_W-1:0] w_raw;
    logic [DIGIT_W-1:0] w_top;
    logic               w_skip;
    logic               w_bit   [NUM_CELLS];
    logic [DIGIT_W-1:0] w_digit [NUM_CELLS];

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_raw    = i_value;
    assign w_top    = w_digit[NUM_CELLS-1];
    // leading zero: drop it unless it is the units digit
    assign w_skip   = !r_seen && (w_top == '0) && (r_cnt != CNT_W'(1));

    // digit cell chain, cell 0 is the units digit
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_first
            sitda_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (r_mag[VALUE_W-1]),
                .i_digit ('0),
                .o_bit   (w_bit[k]),
                .o_digit (w_digit[k])
            );
        end else begin : g_rest
            sitda_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_bit[k-1]),
                .i_digit (w_digit[k-1]),
                .o_bit   (w_bit[k]),
                .o_digit (w_digit[k])
            );
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_cnt == '0) n_state = r_neg ? ST_SIGN : ST_OUT;
            end
            ST_SIGN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (r_cnt == CNT_W'(1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control and output word
    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_seen  = r_seen;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        w_ctrl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_neg        = w_raw[VALUE_W-1];
                    n_mag        = w_raw[VALUE_W-1] ? (VALUE_W'(0) - w_raw) : w_raw;
                    n_cnt        = CONV_LAST;
                    n_seen       = 1'b0;
                    w_ctrl.clear = 1'b1;
                end
            end
            ST_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_mag         = {r_mag[VALUE_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_cnt = OUT_COUNT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_SIGN: begin
                n_valid = 1'b1;
                n_char  = CHAR_MINUS;
            end
            ST_OUT: begin
                w_ctrl.advance = 1'b1;
                n_cnt          = r_cnt - CNT_W'(1);
                if (!w_skip) begin
                    n_seen  = 1'b1;
                    n_valid = 1'b1;
                    n_char  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, w_top};
                    n_last  = (r_cnt == CNT_W'(1));
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_cnt   <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_char <= n_char;
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    `SITDA_ASSERT_NEXT(a_accept_quiet, w_accept, !o_valid, "word strobed right after accept")
    `SITDA_ASSERT_NEXT(a_last_alone, o_valid && o_last, !o_valid, "word follows last word")
    `SITDA_ASSERT_IMP(a_sign_not_last, o_valid && (o_character == CHAR_MINUS), !o_last,
        "minus sign flagged last")
    `SITDA_ASSERT_IMP(a_out_count, r_state == ST_OUT,
        (r_cnt != '0) && (r_cnt <= OUT_COUNT), "digit count out of range")

endmodule

// ===== sv/sitda_cell.sv =====
module sitda_cell
    import sitda_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_bit,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic               o_bit,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] w_adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign w_adj = (r_digit >= DABBLE_LIMIT) ? (r_digit + DABBLE_ADJ) : r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.dabble) begin
            r_digit <= {w_adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctrl.advance) begin
            r_digit <= i_digit;
        end
    end

    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import sitda_pkg::*;

    localparam int RADIX        = 10;
    localparam int MAX_DIGITS   = 10;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 60;
    localparam int WAIT_LIMIT   = 2000;

    // Tracks the decimal text expected for every accepted word
    class decimal_text_tracker;
        logic [CHAR_W-1:0] exp_char_q[$];
        logic              exp_last_q[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        // build the characters of one accepted value, most significant first
        function void note_value(logic [VALUE_W-1:0] raw);
            logic [VALUE_W-1:0] mag;
            int                 digs[MAX_DIGITS];
            int                 nd;
            nd  = 0;
            mag = raw[VALUE_W-1] ? (-raw) : raw;
            do begin
                digs[nd] = int'(mag % RADIX);
                nd++;
                mag = mag / RADIX;
            end while (mag != 0 && nd < MAX_DIGITS);
            if (raw[VALUE_W-1]) begin
                exp_char_q.push_back(CHAR_MINUS);
                exp_last_q.push_back(1'b0);
            end
            for (int k = nd - 1; k >= 0; k--) begin
                exp_char_q.push_back(CHAR_W'(CHAR_ZERO + digs[k]));
                exp_last_q.push_back(k == 0);
            end
        endfunction

        // compare one strobed character with the oldest expectation
        function void check_char(logic [CHAR_W-1:0] ch, logic lst);
            logic [CHAR_W-1:0] e_ch;
            logic              e_lst;
            if (exp_char_q.size() == 0) begin
                $error("unexpected character: actual %0d last %0b", ch, lst);
                errors++;
            end else begin
                e_ch  = exp_char_q.pop_front();
                e_lst = exp_last_q.pop_front();
                if (ch !== e_ch) begin
                    $error("character: expected %0d actual %0d", e_ch, ch);
                    errors++;
                end
                if (lst !== e_lst) begin
                    $error("last: expected %0b actual %0b", e_lst, lst);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return exp_char_q.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic [CHAR_W-1:0]         o_character;
    logic                      o_last;

    decimal_text_tracker text_board = new();

    signed_int_to_decimal_ascii_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor: accepted words and strobed characters
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            text_board.note_value(i_value);
        end
        if (i_rst_n && o_valid) begin
            text_board.check_char(o_character, o_last);
        end
    end

    // present one word and hold it until the block takes it
    task automatic send_value(input logic [VALUE_W-1:0] v);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_value <= $urandom;
        end
    endtask

    // random value: raw bits, zero, or a chosen digit count with random sign
    function automatic logic [VALUE_W-1:0] rand_value();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        bit     neg;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        if ($urandom_range(0, 40) == 0) begin
            return '0;
        end
        n   = $urandom_range(1, MAX_DIGITS);
        neg = 1'($urandom_range(0, 1));
        lo  = 1;
        for (int i = 1; i < n; i++) lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (n == MAX_DIGITS) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = lo + ({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % (hi - lo + 1);
        return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    // stimulus
    initial begin
        logic [VALUE_W-1:0] directed[] = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
            32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd1000000009,
            32'd123456789, -32'sd123456789, 32'd5, -32'sd9, 32'haaaa_aaaa,
            32'h5555_5555
        };
        int sent;
        int burst;
        int waited;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words back to back
        foreach (directed[i]) send_value(directed[i]);
        idle_cycles(3);

        // random bursts with gaps that land on any phase of a conversion
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
                send_value(rand_value());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 60));
        end
        idle_cycles(1);

        // drain
        waited = 0;
        while (text_board.pending() > 0 && waited < WAIT_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (text_board.pending() > 0) begin
            $display("status: fail");
            $finish;
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (text_board.errors == 0 && text_board.pending() == 0) begin
                $display("status: pass");
            end else begin
                $display("status: fail");
            end
            $finish;
        end
    end

    // overall time limit
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
